// File: src/smd64_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smd64_pkg
// Shared widths and the stage record for the multiply-divide pipeline.
// ----------------------------------------------------------------------------
package smd64_pkg;

    localparam int WORD_W          = 32;
    localparam int PROD_W          = 2 * WORD_W - 1;
    localparam int STEPS_PER_STAGE = 3;

    typedef struct packed {
        logic [PROD_W-1:0] dq;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] den;
        logic              neg;
        logic              dz;
    } pipe_t;

endpackage
`default_nettype wire

// File: src/signed_mul_div_64bit_intermediate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_mul_div_64bit_intermediate
// Signed trunc(|a|*|b|/|c|) through an exact 63-bit product and a pipelined
// restoring divider.
// ----------------------------------------------------------------------------
// Takes one operand word per clock and returns one result word per clock
// while neither in_stall nor out_stall is raised. The stages are one for
// the operand magnitudes, one for the 32x32 product, the divider stages at
// the default of three division steps per stage, and one for the sign and
// the divide-by-zero substitution. The divider's restoring steps set the
// stage depth. Stalls collapse bubbles, so the block keeps accepting words
// while a result waits, until every stage is full.
module signed_mul_div_64bit_intermediate #(
    parameter int STEPS_PER_STAGE = smd64_pkg::STEPS_PER_STAGE
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_stall,
    input  wire  signed [smd64_pkg::WORD_W-1:0]    multiplicand,
    input  wire  signed [smd64_pkg::WORD_W-1:0]    multiplier,
    input  wire  signed [smd64_pkg::WORD_W-1:0]    divisor,
    output logic                                   out_valid,
    input  wire                                    out_stall,
    output logic signed [smd64_pkg::WORD_W-1:0]    quotient,
    output logic                                   divide_by_zero
);

    localparam int W          = smd64_pkg::WORD_W;
    localparam int PW         = smd64_pkg::PROD_W;
    localparam int DIV_STAGES = (PW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        logic [W-1:0] r;
        begin
            r = v[W-1] ? (~v + {{(W-1){1'b0}}, 1'b1}) : v;
            return r;
        end
    endfunction

    function automatic smd64_pkg::pipe_t div_step(input smd64_pkg::pipe_t s);
        smd64_pkg::pipe_t r;
        logic [W:0]       t;
        logic [W:0]       diff;
        logic             ge;
        begin
            r    = s;
            t    = {s.rem, s.dq[PW-1]};
            diff = t - {1'b0, s.den};
            ge   = (t >= {1'b0, s.den});
            r.dq  = {s.dq[PW-2:0], ge};
            r.rem = ge ? diff[W-1:0] : t[W-1:0];
            return r;
        end
    endfunction

    // operand stage
    logic             a_vld_reg;
    logic [W-1:0]     mag_a_reg;
    logic [W-1:0]     mag_b_reg;
    logic [W-1:0]     mag_c_reg;
    logic             neg_a_reg;
    logic             dz_a_reg;
    logic             a_ready;

    // product and divider stages
    logic             vld_reg  [0:DIV_STAGES];
    smd64_pkg::pipe_t pipe_reg [0:DIV_STAGES];
    smd64_pkg::pipe_t pipe_next[0:DIV_STAGES];
    logic             rdy      [0:DIV_STAGES+1];
    logic [PW-1:0]    prod_full;

    // output stage
    logic             out_vld_reg;
    logic [W-1:0]     quotient_reg;
    logic             dz_reg;
    logic [W-1:0]     qmag;
    logic [W-1:0]     quotient_next;

    assign rdy[DIV_STAGES+1] = !out_vld_reg || !out_stall;
    assign a_ready           = !a_vld_reg || rdy[0];
    assign in_stall          = !a_ready;

    // operand stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            mag_a_reg <= mag(multiplicand);
            mag_b_reg <= mag(multiplier);
            mag_c_reg <= mag(divisor);
            neg_a_reg <= multiplicand[W-1] ^ multiplier[W-1] ^ divisor[W-1];
            dz_a_reg  <= (divisor == '0);
        end
    end

    // product stage
    assign prod_full = PW'(mag_a_reg) * PW'(mag_b_reg);

    always_comb
    begin
        pipe_next[0].dq  = prod_full;
        pipe_next[0].rem = '0;
        pipe_next[0].den = mag_c_reg;
        pipe_next[0].neg = neg_a_reg;
        pipe_next[0].dz  = dz_a_reg;
    end

    generate
        for (genvar k = 0; k <= DIV_STAGES; k++)
        begin : g_stage
            logic src_vld;

            if (k == 0)
            begin : g_src0
                assign src_vld = a_vld_reg;
            end
            else
            begin : g_srck
                assign src_vld = vld_reg[k-1];
            end

            assign rdy[k] = !vld_reg[k] || rdy[k+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (rdy[k])
                begin
                    vld_reg[k] <= src_vld;
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k] && src_vld)
                begin
                    pipe_reg[k] <= pipe_next[k];
                end
            end

            // advance the restoring divider by up to STEPS_PER_STAGE steps
            if (k < DIV_STAGES)
            begin : g_div
                always_comb
                begin
                    smd64_pkg::pipe_t tmp;
                    tmp = pipe_reg[k];
                    for (int j = 0; j < STEPS_PER_STAGE; j++)
                    begin
                        if (k * STEPS_PER_STAGE + j < PW)
                        begin
                            tmp = div_step(tmp);
                        end
                    end
                    pipe_next[k+1] = tmp;
                end
            end
        end
    endgenerate

    // sign and divide-by-zero stage
    always_comb
    begin
        qmag          = pipe_reg[DIV_STAGES].dz ? '1 : pipe_reg[DIV_STAGES].dq[W-1:0];
        quotient_next = pipe_reg[DIV_STAGES].neg ? (~qmag + {{(W-1){1'b0}}, 1'b1}) : qmag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (rdy[DIV_STAGES+1])
        begin
            out_vld_reg <= vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[DIV_STAGES+1] && vld_reg[DIV_STAGES])
        begin
            quotient_reg <= quotient_next;
            dz_reg       <= pipe_reg[DIV_STAGES].dz;
        end
    end

    assign out_valid      = out_vld_reg;
    assign quotient       = quotient_reg;
    assign divide_by_zero = dz_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_vld_reg && out_stall))
        else $error("input stalled while the pipeline has room");

    a_dz_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && dz_reg) |-> (quotient_reg == '1 || quotient_reg == {{(W-1){1'b0}}, 1'b1}))
        else $error("divide-by-zero word without a unit magnitude result");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DIV_STAGES] && !pipe_reg[DIV_STAGES].dz)
        |-> (pipe_reg[DIV_STAGES].rem < pipe_reg[DIV_STAGES].den))
        else $error("final remainder not below the divisor");

    a_out_from_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(vld_reg[DIV_STAGES]))
        else $error("output word appeared without a word in the last stage");
`endif

endmodule
`default_nettype wire

// File: tb/smd_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_result_checker
// Watches both channels of the signed multiply-divide block. For each
// accepted operand word it computes the expected signed quotient and the
// divide-by-zero flag. Each accepted result word is compared, field by
// field, with the oldest expected one. Failures and progress are counted
// for the top.
// ----------------------------------------------------------------------------
module smd_result_checker (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    input  wire                                 in_stall,
    input  wire signed [smd64_pkg::WORD_W-1:0]  multiplicand,
    input  wire signed [smd64_pkg::WORD_W-1:0]  multiplier,
    input  wire signed [smd64_pkg::WORD_W-1:0]  divisor,
    input  wire                                 out_valid,
    input  wire                                 out_stall,
    input  wire signed [smd64_pkg::WORD_W-1:0]  quotient,
    input  wire                                 divide_by_zero,
    output int                                  failures,
    output int                                  outstanding,
    output int                                  results_checked,
    output int                                  zero_divisors
);

    localparam int W = smd64_pkg::WORD_W;

    typedef logic [W-1:0] word_t;

    typedef struct packed {
        word_t quotient;
        logic  divide_by_zero;
    } muldiv_result_t;

    localparam word_t ALL_ONES = '1;
    localparam word_t ZERO     = '0;

    muldiv_result_t awaited_results[$];
    int fail_count   = 0;
    int queued_count = 0;
    int result_count = 0;
    int dz_count     = 0;

    assign failures        = fail_count;
    assign outstanding     = queued_count;
    assign results_checked = result_count;
    assign zero_divisors   = dz_count;

    function automatic muldiv_result_t scaled_quotient(word_t a, word_t b, word_t c);
        word_t          mag_a;
        word_t          mag_b;
        word_t          mag_c;
        logic [2*W-1:0] product;
        muldiv_result_t r;
        mag_a   = a[W-1] ? word_t'(-a) : a;
        mag_b   = b[W-1] ? word_t'(-b) : b;
        mag_c   = c[W-1] ? word_t'(-c) : c;
        product = {{W{1'b0}}, mag_a} * {{W{1'b0}}, mag_b};
        if (mag_c == ZERO)
        begin
            r.quotient       = ALL_ONES;
            r.divide_by_zero = 1'b1;
        end
        else
        begin
            r.quotient       = word_t'(product / {{W{1'b0}}, mag_c});
            r.divide_by_zero = 1'b0;
        end
        if (a[W-1] ^ b[W-1] ^ c[W-1])
        begin
            r.quotient = -r.quotient;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        muldiv_result_t got;
        muldiv_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                awaited_results.push_back(scaled_quotient(multiplicand, multiplier, divisor));
            end
            if (out_valid && !out_stall)
            begin
                got.quotient       = quotient;
                got.divide_by_zero = divide_by_zero;
                result_count++;
                if (awaited_results.size() == 0)
                begin
                    $error("result word with nothing expected: quotient %0d, divide_by_zero %0b",
                           $signed(got.quotient), got.divide_by_zero);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.divide_by_zero)
                    begin
                        dz_count++;
                    end
                    if (got.quotient !== want.quotient)
                    begin
                        $error("quotient: expected %0d, actual %0d",
                               $signed(want.quotient), $signed(got.quotient));
                        fail_count++;
                    end
                    if (got.divide_by_zero !== want.divide_by_zero)
                    begin
                        $error("divide_by_zero: expected %0b, actual %0b",
                               want.divide_by_zero, got.divide_by_zero);
                        fail_count++;
                    end
                end
            end
            queued_count = awaited_results.size();
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the signed multiply-divide block.
// A directed set covers the operand extremes, the zero divisor and seven
// of the eight sign mixes. Random operand words follow, with bursts of
// sender and receiver idling, one long output hold-off that fills the
// pipeline, one pause until the block drains and a last full-rate stretch.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int W = smd64_pkg::WORD_W;

    typedef logic [W-1:0] word_t;

    localparam word_t MOST_NEG  = {1'b1, {(W-1){1'b0}}};
    localparam word_t MOST_POS  = ~MOST_NEG;
    localparam word_t ZERO      = '0;
    localparam word_t ONE       = word_t'(1);
    localparam word_t MINUS_ONE = '1;

    localparam int LIMIT     = 300000;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN     = 40;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               out_stall    = 1'b0;
    logic signed [W-1:0] multiplicand = '0;
    logic signed [W-1:0] multiplier   = '0;
    logic signed [W-1:0] divisor      = '0;

    wire                in_stall;
    wire                out_valid;
    wire signed [W-1:0] quotient;
    wire                divide_by_zero;

    logic tx_idling   = 1'b0;
    logic rx_idling   = 1'b0;
    logic hold_req    = 1'b0;
    logic hold_served = 1'b0;

    int failures;
    int outstanding;
    int results_checked;
    int zero_divisors;
    int words_sent  = 0;
    int cycle_count = 0;

    always #5 clk = ~clk;

    signed_mul_div_64bit_intermediate dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .multiplicand   (multiplicand),
        .multiplier     (multiplier),
        .divisor        (divisor),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .quotient       (quotient),
        .divide_by_zero (divide_by_zero)
    );

    smd_result_checker result_watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .multiplicand    (multiplicand),
        .multiplier      (multiplier),
        .divisor         (divisor),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .quotient        (quotient),
        .divide_by_zero  (divide_by_zero),
        .failures        (failures),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .zero_divisors   (zero_divisors)
    );

    function automatic word_t pick_operand();
        word_t v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       v = ZERO;
                    1:       v = ONE;
                    2:       v = MINUS_ONE;
                    3:       v = MOST_NEG;
                    default: v = MOST_POS;
                endcase
            end
            1, 2:
            begin
                v = word_t'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v;
                end
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic word_t pick_divisor();
        word_t v;
        if ($urandom_range(0, 15) == 0)
        begin
            v = ZERO;
        end
        else
        begin
            v = pick_operand();
        end
        return v;
    endfunction

    // enter and leave at a falling edge
    task automatic send_word(input word_t a, input word_t b, input word_t c);
        in_valid     = 1'b1;
        multiplicand = a;
        multiplier   = b;
        divisor      = c;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
        @(negedge clk);
        if (tx_idling && $urandom_range(0, 5) == 0)
        begin
            in_valid     = 1'b0;
            multiplicand = $urandom;
            multiplier   = $urandom;
            divisor      = $urandom;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
    endtask

    task automatic send_random_words(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_word(pick_operand(), pick_operand(), pick_divisor());
        end
    endtask

    // receiver side: random stall bursts and the single long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_served)
            begin
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall   = 1'b0;
                hold_served = 1'b1;
            end
            else if (rx_idling && $urandom_range(0, 4) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped at the cycle limit with %0d results outstanding", outstanding);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_word(ZERO, ZERO, ONE);
        send_word(ONE, ONE, ONE);
        send_word(word_t'(7), word_t'(3), word_t'(2));
        send_word(word_t'(-7), word_t'(3), word_t'(2));
        send_word(word_t'(7), word_t'(-3), word_t'(-2));
        send_word(MINUS_ONE, MINUS_ONE, MINUS_ONE);
        send_word(MOST_POS, MOST_POS, ONE);
        send_word(MOST_POS, MOST_POS, word_t'(2));
        send_word(MOST_POS, MOST_POS, MOST_POS);
        send_word(MOST_POS, MOST_POS, MOST_NEG);
        send_word(MOST_NEG, MOST_NEG, ONE);
        send_word(MOST_NEG, MOST_NEG, MINUS_ONE);
        send_word(MOST_NEG, ONE, MINUS_ONE);
        send_word(MOST_NEG, MOST_NEG, MOST_NEG);
        send_word(ONE, ONE, MOST_NEG);
        send_word(ZERO, MOST_NEG, MINUS_ONE);
        send_word(word_t'(5), word_t'(7), ZERO);
        send_word(word_t'(-5), word_t'(7), ZERO);
        send_word(word_t'(-5), word_t'(-7), ZERO);
        send_word(MOST_NEG, MOST_NEG, ZERO);
        send_word(ZERO, ZERO, ZERO);
        send_word(word_t'(123456789), word_t'(987654321), word_t'(3));
        send_word(word_t'(-123456789), word_t'(987654321), word_t'(-40000));

        tx_idling = 1'b1;
        rx_idling = 1'b1;
        send_random_words(300);

        // fill the pipeline behind a long output hold-off
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        hold_req  = 1'b1;
        send_random_words(80);

        in_valid = 1'b0;
        wait (outstanding == 0);
        @(negedge clk);

        rx_idling = 1'b1;
        send_random_words(300);
        rx_idling = 1'b0;
        tx_idling = 1'b1;
        send_random_words(300);
        tx_idling = 1'b0;
        send_random_words(350);

        in_valid = 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d operand words and %0d checked results, %0d with a zero divisor,",
                 words_sent, results_checked, zero_divisors);
        $display("with sender and receiver idling, a %0d-cycle output hold-off and a drain pause",
                 LONG_HOLD);
        if (failures == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/smd64_pkg.sv
src/signed_mul_div_64bit_intermediate.sv
tb/smd_result_checker.sv
tb/tb_top.sv
